// File: src/nnis_pkg.sv
package nnis_pkg;

	localparam int MAX_SRC_DIM_DEF = 64;
	localparam int MAX_DST_DIM_DEF = 4096;
	localparam int RESET_DIM       = 64;
	localparam int PIX_W           = 8;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic vld;
		logic op;
		logic err;
	} ctl_t;

endpackage

// File: src/nnis_prep.sv
module nnis_prep import nnis_pkg::*; #(
	parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
	parameter int MAX_DST_DIM = MAX_DST_DIM_DEF,
	localparam int SW = $clog2(MAX_SRC_DIM + 1),
	localparam int DW = $clog2(MAX_DST_DIM + 1),
	localparam int CW = $clog2(MAX_DST_DIM),
	localparam int QW = $clog2(MAX_SRC_DIM),
	localparam int NW = CW + SW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic             in_op,
	input  logic [CW-1:0]    in_x,
	input  logic [CW-1:0]    in_y,
	input  logic [PIX_W-1:0] in_pix,
	input  logic [SW-1:0]    src_w,
	input  logic [SW-1:0]    src_h,
	input  logic [DW-1:0]    dst_w,
	input  logic [DW-1:0]    dst_h,
	output ctl_t             ctl_s1,
	output logic [NW-1:0]    nx_s1,
	output logic [NW-1:0]    ny_s1,
	output logic [QW-1:0]    px_s1,
	output logic [QW-1:0]    py_s1,
	output logic [PIX_W-1:0] pix_s1
);

	localparam int LW0 = (CW > SW) ? CW : SW;
	localparam int LW  = (LW0 > DW) ? LW0 : DW;

	logic sz_bad;
	logic rng_bad;
	ctl_t ctl_d;

	assign sz_bad = (src_w == '0) || (LW'(src_w) > LW'(MAX_SRC_DIM))
		|| (src_h == '0) || (LW'(src_h) > LW'(MAX_SRC_DIM))
		|| (dst_w == '0) || (LW'(dst_w) > LW'(MAX_DST_DIM))
		|| (dst_h == '0) || (LW'(dst_h) > LW'(MAX_DST_DIM));

	always_comb begin
		if (in_op == OP_WRITE) begin
			rng_bad = (LW'(in_x) >= LW'(src_w)) || (LW'(in_y) >= LW'(src_h));
		end else begin
			rng_bad = (LW'(in_x) >= LW'(dst_w)) || (LW'(in_y) >= LW'(dst_h));
		end
		ctl_d.vld = in_vld;
		ctl_d.op  = in_op;
		ctl_d.err = sz_bad | rng_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1  <= NW'(in_x) * NW'(src_w);
			ny_s1  <= NW'(in_y) * NW'(src_h);
			px_s1  <= in_x[QW-1:0];
			py_s1  <= in_y[QW-1:0];
			pix_s1 <= in_pix;
		end
	end

endmodule

// File: src/nnis_div.sv
module nnis_div import nnis_pkg::*; #(
	parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
	parameter int MAX_DST_DIM = MAX_DST_DIM_DEF,
	localparam int SW = $clog2(MAX_SRC_DIM + 1),
	localparam int DW = $clog2(MAX_DST_DIM + 1),
	localparam int CW = $clog2(MAX_DST_DIM),
	localparam int QW = $clog2(MAX_SRC_DIM),
	localparam int NW = CW + SW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl_i,
	input  logic [NW-1:0]    nx,
	input  logic [NW-1:0]    ny,
	input  logic [QW-1:0]    px,
	input  logic [QW-1:0]    py,
	input  logic [PIX_W-1:0] pix,
	input  logic [DW-1:0]    dst_w,
	input  logic [DW-1:0]    dst_h,
	output ctl_t             ctl_o,
	output logic [QW-1:0]    qx,
	output logic [QW-1:0]    qy,
	output logic [QW-1:0]    px_o,
	output logic [QW-1:0]    py_o,
	output logic [PIX_W-1:0] pix_o
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	ctl_t             ctl_s [QW];
	logic [RW-1:0]    rx_s  [QW];
	logic [RW-1:0]    ry_s  [QW];
	logic [QW-1:0]    qx_s  [QW];
	logic [QW-1:0]    qy_s  [QW];
	logic [QW-1:0]    px_s  [QW];
	logic [QW-1:0]    py_s  [QW];
	logic [PIX_W-1:0] pix_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;

		ctl_t             ctl_a;
		logic [RW-1:0]    rx_a;
		logic [RW-1:0]    ry_a;
		logic [QW-1:0]    qx_a;
		logic [QW-1:0]    qy_a;
		logic [QW-1:0]    px_a;
		logic [QW-1:0]    py_a;
		logic [PIX_W-1:0] pix_a;
		logic [RW-1:0]    dx;
		logic [RW-1:0]    dy;
		logic             gex;
		logic             gey;

		if (k == 0) begin : g_head
			assign ctl_a = ctl_i;
			assign rx_a  = RW'(nx);
			assign ry_a  = RW'(ny);
			assign qx_a  = '0;
			assign qy_a  = '0;
			assign px_a  = px;
			assign py_a  = py;
			assign pix_a = pix;
		end else begin : g_body
			assign ctl_a = ctl_s[k-1];
			assign rx_a  = rx_s[k-1];
			assign ry_a  = ry_s[k-1];
			assign qx_a  = qx_s[k-1];
			assign qy_a  = qy_s[k-1];
			assign px_a  = px_s[k-1];
			assign py_a  = py_s[k-1];
			assign pix_a = pix_s[k-1];
		end

		assign dx  = RW'(dst_w) << B;
		assign dy  = RW'(dst_h) << B;
		assign gex = (rx_a >= dx);
		assign gey = (ry_a >= dy);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_a;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k]    <= gex ? rx_a - dx : rx_a;
				ry_s[k]    <= gey ? ry_a - dy : ry_a;
				qx_s[k]    <= qx_a | (QW'(gex) << B);
				qy_s[k]    <= qy_a | (QW'(gey) << B);
				px_s[k]    <= px_a;
				py_s[k]    <= py_a;
				pix_s[k]   <= pix_a;
			end
		end
	end

	assign ctl_o = ctl_s[QW-1];
	assign qx    = qx_s[QW-1];
	assign qy    = qy_s[QW-1];
	assign px_o  = px_s[QW-1];
	assign py_o  = py_s[QW-1];
	assign pix_o = pix_s[QW-1];

endmodule

// File: src/nnis_store.sv
module nnis_store import nnis_pkg::*; #(
	parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
	localparam int SW = $clog2(MAX_SRC_DIM + 1),
	localparam int QW = $clog2(MAX_SRC_DIM),
	localparam int AW = $clog2(MAX_SRC_DIM * MAX_SRC_DIM),
	localparam int PW = QW + SW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl_i,
	input  logic [QW-1:0]    qx,
	input  logic [QW-1:0]    qy,
	input  logic [QW-1:0]    px,
	input  logic [QW-1:0]    py,
	input  logic [PIX_W-1:0] pix,
	input  logic [SW-1:0]    src_w,
	output logic             out_vld,
	output logic             out_status,
	output logic [PIX_W-1:0] out_pix
);

	localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;

	logic [PIX_W-1:0] mem [DEPTH];

	logic [QW-1:0]    sx;
	logic [QW-1:0]    sy;
	logic [PW-1:0]    lin;
	ctl_t             ctl_s1;
	logic [AW-1:0]    addr_s1;
	logic [PIX_W-1:0] pix_s1;
	ctl_t             ctl_s2;
	logic [PIX_W-1:0] rd_s2;
	logic             we;

	assign sx  = (ctl_i.op == OP_WRITE) ? px : qx;
	assign sy  = (ctl_i.op == OP_WRITE) ? py : qy;
	assign lin = PW'(sy) * PW'(src_w) + PW'(sx);
	assign we  = en && ctl_s1.vld && !ctl_s1.err && (ctl_s1.op == OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1 <= lin[AW-1:0];
			pix_s1  <= pix;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_s1] <= pix_s1;
		end
		if (en) begin
			rd_s2 <= mem[addr_s1];
		end
	end

	assign out_vld    = ctl_s2.vld;
	assign out_status = ctl_s2.err;
	assign out_pix    = (ctl_s2.op == OP_READ && !ctl_s2.err) ? rd_s2 : '0;

endmodule

// File: src/nearest_neighbor_image_scaler_unit.sv
// Each word passes the prep register, the divider stages and the store registers.
// One word per unstalled cycle; the restoring divider has one stage per quotient bit.
// A stalled output holds the whole pipeline; s_tready follows the output register.
// Reset: arst_n clears all valid bits and sets the four size registers to 64.
// The pixel store is not cleared; no clearing pass is run.
module nearest_neighbor_image_scaler_unit import nnis_pkg::*; #(
	parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
	parameter int MAX_DST_DIM = MAX_DST_DIM_DEF,
	localparam int SW   = $clog2(MAX_SRC_DIM + 1),
	localparam int DW   = $clog2(MAX_DST_DIM + 1),
	localparam int CW   = $clog2(MAX_DST_DIM),
	localparam int CFW  = (SW > DW) ? SW : DW,
	localparam int TIW  = ((2 * CW + PIX_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TIW-1:0]       s_tdata,  // coord_x, coord_y, pixel_in, zero pad
	input  logic                 s_tuser,  // op
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PIX_W-1:0]     m_tdata,  // pixel_out
	output logic                 m_tuser,  // status
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFW-1:0]       cfg_data
);

	localparam int QW = $clog2(MAX_SRC_DIM);
	localparam int NW = CW + SW;

	logic [SW-1:0] src_w_q;
	logic [SW-1:0] src_h_q;
	logic [DW-1:0] dst_w_q;
	logic [DW-1:0] dst_h_q;
	logic          en;

	ctl_t             ctl_p;
	logic [NW-1:0]    nx_p;
	logic [NW-1:0]    ny_p;
	logic [QW-1:0]    px_p;
	logic [QW-1:0]    py_p;
	logic [PIX_W-1:0] pix_p;

	ctl_t             ctl_d;
	logic [QW-1:0]    qx_d;
	logic [QW-1:0]    qy_d;
	logic [QW-1:0]    px_d;
	logic [QW-1:0]    py_d;
	logic [PIX_W-1:0] pix_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SW'(RESET_DIM);
			src_h_q <= SW'(RESET_DIM);
			dst_w_q <= DW'(RESET_DIM);
			dst_h_q <= DW'(RESET_DIM);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SRC_WIDTH:  src_w_q <= cfg_data[SW-1:0];
				REG_SRC_HEIGHT: src_h_q <= cfg_data[SW-1:0];
				REG_DST_WIDTH:  dst_w_q <= cfg_data[DW-1:0];
				REG_DST_HEIGHT: dst_h_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	// advance when the output register is empty or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	nnis_prep #(
		.MAX_SRC_DIM(MAX_SRC_DIM),
		.MAX_DST_DIM(MAX_DST_DIM)
	) u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_tvalid),
		.in_op  (s_tuser),
		.in_x   (s_tdata[CW-1:0]),
		.in_y   (s_tdata[2*CW-1:CW]),
		.in_pix (s_tdata[2*CW+PIX_W-1:2*CW]),
		.src_w  (src_w_q),
		.src_h  (src_h_q),
		.dst_w  (dst_w_q),
		.dst_h  (dst_h_q),
		.ctl_s1 (ctl_p),
		.nx_s1  (nx_p),
		.ny_s1  (ny_p),
		.px_s1  (px_p),
		.py_s1  (py_p),
		.pix_s1 (pix_p)
	);

	nnis_div #(
		.MAX_SRC_DIM(MAX_SRC_DIM),
		.MAX_DST_DIM(MAX_DST_DIM)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_p),
		.nx     (nx_p),
		.ny     (ny_p),
		.px     (px_p),
		.py     (py_p),
		.pix    (pix_p),
		.dst_w  (dst_w_q),
		.dst_h  (dst_h_q),
		.ctl_o  (ctl_d),
		.qx     (qx_d),
		.qy     (qy_d),
		.px_o   (px_d),
		.py_o   (py_d),
		.pix_o  (pix_d)
	);

	nnis_store #(
		.MAX_SRC_DIM(MAX_SRC_DIM)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_i      (ctl_d),
		.qx         (qx_d),
		.qy         (qy_d),
		.px         (px_d),
		.py         (py_d),
		.pix        (pix_d),
		.src_w      (src_w_q),
		.out_vld    (m_tvalid),
		.out_status (m_tuser),
		.out_pix    (m_tdata)
	);

endmodule

// File: src/nnis_checker.sv
module nnis_checker import nnis_pkg::*; #(
	parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
	parameter int MAX_DST_DIM = MAX_DST_DIM_DEF,
	localparam int SW   = $clog2(MAX_SRC_DIM + 1),
	localparam int DW   = $clog2(MAX_DST_DIM + 1),
	localparam int CW   = $clog2(MAX_DST_DIM),
	localparam int CFW  = (SW > DW) ? SW : DW,
	localparam int TIW  = ((2 * CW + PIX_W + 7) / 8) * 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [TIW-1:0]       s_tdata,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [PIX_W-1:0]     m_tdata,
	input logic                 m_tuser,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFW-1:0]       cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("refused word carries a nonzero pixel");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown({s_tuser, s_tdata}))
		else $error("input word carries unknown bits");

	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown({cfg_idx, cfg_data}))
		else $error("register write carries unknown bits");

endmodule

bind nearest_neighbor_image_scaler_unit nnis_checker #(
	.MAX_SRC_DIM(MAX_SRC_DIM),
	.MAX_DST_DIM(MAX_DST_DIM)
) u_nnis_checker (.*);
